@@ hdl/ndt_pkg.sv @@
// Shared types, codes and constants for the number-to-digit-tile formatter.
package ndt_pkg;

	localparam int DEC_DIGITS = 5;
	localparam int HEX_DIGITS = 8;
	localparam int MAX_DIGITS = 8;

	localparam logic [1:0] OP_DEC_ZERO  = 2'd0;
	localparam logic [1:0] OP_DEC_SPACE = 2'd1;
	localparam logic [1:0] OP_HEX       = 2'd2;

	localparam logic [6:0] ASCII_ZERO  = 7'h30;
	localparam logic [6:0] ASCII_A     = 7'h41;
	localparam logic [6:0] ASCII_SPACE = 7'h20;

	// floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 16-bit v
	localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
	localparam int          RECIP_SHIFT = 19;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic emit_step;
	} dp_cmd_t;

	typedef struct packed {
		logic start_empty;
		logic start_dec;
		logic conv_done;
		logic emit_final;
		logic out_free;
	} dp_sts_t;

endpackage

@@ hdl/ndt_ctrl.sv @@
// Controller state machine: accept, decimal conversion, tile write sequencing.
module ndt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ndt_pkg::dp_sts_t sts,
	output ndt_pkg::dp_cmd_t cmd
);

	ndt_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ndt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.emit_step = 1'b0;
		in_stall      = 1'b1;
		unique case (state_q)
			ndt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					// drop requests that produce no writes right here
					if (sts.start_empty) begin
						state_d = ndt_pkg::ST_IDLE;
					end else if (sts.start_dec) begin
						state_d = ndt_pkg::ST_CONV;
					end else begin
						state_d = ndt_pkg::ST_EMIT;
					end
				end
			end
			ndt_pkg::ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done) begin
					state_d = ndt_pkg::ST_EMIT;
				end
			end
			ndt_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_step = 1'b1;
					if (sts.emit_final) begin
						state_d = ndt_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ndt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/ndt_dpath.sv @@
// Datapath: request registers, divide-by-ten digit unit, digit store, output register.
module ndt_dpath #(
	parameter int HEX_DIGITS = ndt_pkg::HEX_DIGITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ndt_pkg::dp_cmd_t cmd,
	output ndt_pkg::dp_sts_t sts,
	input  logic [1:0]       opcode,
	input  logic [1:0]       plane,
	input  logic [3:0]       palette,
	input  logic [4:0]       column,
	input  logic [4:0]       row,
	input  logic [31:0]      number,
	input  logic [3:0]       digit_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       out_plane,
	output logic [3:0]       out_palette,
	output logic [5:0]       out_column,
	output logic [4:0]       out_row,
	output logic [6:0]       tile_code,
	output logic             last
);

	localparam int IDX_W = $clog2(ndt_pkg::MAX_DIGITS);

	// request registers
	logic                                  space_q;
	logic [1:0]                            plane_q;
	logic [3:0]                            palette_q;
	logic [4:0]                            column_q;
	logic [4:0]                            row_q;
	logic [ndt_pkg::MAX_DIGITS-1:0][3:0]   dig_q;
	logic [15:0]                           val_q;
	logic [IDX_W-1:0]                      conv_q;
	logic [IDX_W-1:0]                      k_q;
	logic [IDX_W-1:0]                      pos_q;
	logic                                  leading_q;

	// output register
	logic                                  out_valid_q;
	logic [1:0]                            out_plane_q;
	logic [3:0]                            out_palette_q;
	logic [5:0]                            out_column_q;
	logic [4:0]                            out_row_q;
	logic [6:0]                            tile_code_q;
	logic                                  last_q;

	logic [3:0]  cnt_clamp;
	logic        in_is_dec;
	logic [31:0] prod;
	logic [12:0] quot;
	logic [15:0] quot_x10;
	logic [3:0]  rem;
	logic [3:0]  cur_dig;
	logic        blank;
	logic [6:0]  code;
	logic        out_free;

	assign in_is_dec = (opcode == ndt_pkg::OP_DEC_ZERO) || (opcode == ndt_pkg::OP_DEC_SPACE);

	always_comb begin
		if (in_is_dec) begin
			cnt_clamp = (digit_count > 4'(ndt_pkg::DEC_DIGITS)) ?
				4'(ndt_pkg::DEC_DIGITS) : digit_count;
		end else begin
			cnt_clamp = (digit_count > 4'(HEX_DIGITS)) ? 4'(HEX_DIGITS) : digit_count;
		end
	end

	// one decimal digit per cycle, least significant first
	assign prod     = val_q * ndt_pkg::RECIP_TEN;
	assign quot     = prod[31:ndt_pkg::RECIP_SHIFT];
	assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem      = 4'(val_q - quot_x10);

	assign cur_dig = dig_q[k_q];
	assign blank   = space_q && leading_q && (cur_dig == 4'd0) && (k_q != '0);

	always_comb begin
		if (blank) begin
			code = ndt_pkg::ASCII_SPACE;
		end else if (cur_dig < 4'd10) begin
			code = ndt_pkg::ASCII_ZERO + 7'(cur_dig);
		end else begin
			code = ndt_pkg::ASCII_A + 7'(cur_dig - 4'd10);
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign sts.start_empty = (cnt_clamp == 4'd0) || !(in_is_dec || (opcode == ndt_pkg::OP_HEX));
	assign sts.start_dec   = in_is_dec;
	assign sts.conv_done   = (conv_q == IDX_W'(ndt_pkg::DEC_DIGITS - 1));
	assign sts.emit_final  = (k_q == '0);
	assign sts.out_free    = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			space_q   <= (opcode == ndt_pkg::OP_DEC_SPACE);
			plane_q   <= plane;
			palette_q <= palette;
			column_q  <= column;
			row_q     <= row;
			dig_q     <= number;
			val_q     <= number[15:0];
			conv_q    <= '0;
			k_q       <= IDX_W'(cnt_clamp - 4'd1);
			pos_q     <= '0;
			leading_q <= 1'b1;
		end else if (cmd.conv_step) begin
			dig_q[conv_q] <= rem;
			val_q         <= {3'b000, quot};
			conv_q        <= conv_q + 1'b1;
		end else if (cmd.emit_step) begin
			k_q       <= k_q - 1'b1;
			pos_q     <= pos_q + 1'b1;
			leading_q <= blank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			out_plane_q   <= plane_q;
			out_palette_q <= palette_q;
			out_column_q  <= {1'b0, column_q} + 6'(pos_q);
			out_row_q     <= row_q;
			tile_code_q   <= code;
			last_q        <= (k_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_plane   = out_plane_q;
	assign out_palette = out_palette_q;
	assign out_column  = out_column_q;
	assign out_row     = out_row_q;
	assign tile_code   = tile_code_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> out_free)
		else $error("tile write issued while output register is held");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step && (k_q == '0) |=> out_valid_q && last_q)
		else $error("final digit not marked last");

	a_conv_decimal_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.conv_step |-> !cmd.load && !cmd.emit_step && (conv_q < IDX_W'(ndt_pkg::DEC_DIGITS)))
		else $error("conversion step out of sequence");
`endif

endmodule

@@ hdl/number_to_digit_tiles_core.sv @@
// Top level of the number-to-digit-tile formatter: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  request  | in_valid / in_stall  | opcode plane palette column row number digit_count
//  write    | out_valid / out_stall| out_plane out_palette out_column out_row tile_code last
//
// A request is accepted in the idle state; decimal requests then pass all five digits
// through the divide-by-ten unit (one digit per cycle), and each request with writes then
// issues one tile write per cycle through the output register unless a write is stalled.
// Requests with a count of zero or an unused opcode are accepted with no writes.
// A stalled write holds in the output register and stops the sequence; in_stall is high
// from acceptance until the last write is issued. Reset clears the state machine and
// the output valid flag.
module number_to_digit_tiles_core #(
	parameter int HEX_DIGITS = ndt_pkg::HEX_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [1:0]  plane,
	input  logic [3:0]  palette,
	input  logic [4:0]  column,
	input  logic [4:0]  row,
	input  logic [31:0] number,
	input  logic [3:0]  digit_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_plane,
	output logic [3:0]  out_palette,
	output logic [5:0]  out_column,
	output logic [4:0]  out_row,
	output logic [6:0]  tile_code,
	output logic        last
);

	ndt_pkg::dp_cmd_t cmd;
	ndt_pkg::dp_sts_t sts;

	ndt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ndt_dpath #(
		.HEX_DIGITS (HEX_DIGITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.plane       (plane),
		.palette     (palette),
		.column      (column),
		.row         (row),
		.number      (number),
		.digit_count (digit_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_plane   (out_plane),
		.out_palette (out_palette),
		.out_column  (out_column),
		.out_row     (out_row),
		.tile_code   (tile_code),
		.last        (last)
	);

endmodule
